@@ rtl/trm_pkg.sv @@
package trm_pkg;

  localparam int NUM_REGS   = 8;
  localparam int MEM_DEPTH  = 256;
  localparam int PROG_DEPTH = 256;

  localparam int REG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int RIDX_W  = $clog2(NUM_REGS);
  localparam int MADDR_W = $clog2(MEM_DEPTH);

  // field widths of the channels
  localparam int OP_W    = 4;
  localparam int RSEL_W  = 3;
  localparam int ADDR_W  = 8;
  localparam int COND_W  = 4;
  localparam int PC_W    = 9;

  localparam logic [PC_W-1:0] PROG_LIMIT = PC_W'(PROG_DEPTH);

  localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
  localparam logic [OP_W-1:0] OP_STORE = 4'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd5;
  localparam logic [OP_W-1:0] OP_READ  = 4'd6;
  localparam logic [OP_W-1:0] OP_PRINT = 4'd7;
  localparam logic [OP_W-1:0] OP_IF    = 4'd8;
  localparam logic [OP_W-1:0] OP_JMP   = 4'd14;

  localparam logic [COND_W-1:0] CMP_EQ = 4'd9;
  localparam logic [COND_W-1:0] CMP_GT = 4'd10;
  localparam logic [COND_W-1:0] CMP_LT = 4'd11;
  localparam logic [COND_W-1:0] CMP_GE = 4'd12;
  localparam logic [COND_W-1:0] CMP_LE = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [RSEL_W-1:0]  reg_a;
    logic [RSEL_W-1:0]  reg_b;
    logic [RSEL_W-1:0]  reg_c;
    logic [ADDR_W-1:0]  mem_addr;
    logic [COND_W-1:0]  cond;
    logic [PC_W-1:0]    target_line;
    logic signed [REG_W-1:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              halted;
    logic              print_valid;
    logic [RSEL_W-1:0] print_reg;
    logic [REG_W-1:0]  print_value;
    logic              reg_we;
    logic [REG_W-1:0]  reg_wdata;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
  } exec_t;

endpackage

@@ rtl/trm_ifs.sv @@
interface trm_instr_if;
  import trm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [RSEL_W-1:0]       reg_a;
  logic [RSEL_W-1:0]       reg_b;
  logic [RSEL_W-1:0]       reg_c;
  logic [ADDR_W-1:0]       mem_addr;
  logic [COND_W-1:0]       cond;
  logic [PC_W-1:0]         target_line;
  logic signed [REG_W-1:0] read_value;

  modport source (output valid, op, reg_a, reg_b, reg_c, mem_addr, cond, target_line,
                  read_value, input ready);
  modport sink (input valid, op, reg_a, reg_b, reg_c, mem_addr, cond, target_line,
                read_value, output ready);
endinterface

interface trm_result_if;
  import trm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [PC_W-1:0]         next_index;
  logic                    halted;
  logic                    print_valid;
  logic [RSEL_W-1:0]       print_reg;
  logic signed [REG_W-1:0] print_value;

  modport source (output valid, next_index, halted, print_valid, print_reg, print_value,
                  input ready);
  modport sink (input valid, next_index, halted, print_valid, print_reg, print_value,
                output ready);
endinterface

interface trm_cfg_if;
  import trm_pkg::*;
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/toy_register_machine_execute.sv @@
// toy register machine, execute unit
//
// instr carries one decoded instruction per transaction; result returns one
// transaction per instruction with the next instruction index, the halt flag
// and, for a print, the register index and its value. cfg writes the program
// length; write it only while no instruction is in flight.
//
// a result is offered from the result register once its instruction has
// passed the execute register. one instruction per cycle while the receiver
// takes results. operand reads of the register file and the byte memory are
// started at acceptance and come back registered; a write by the instruction
// ahead is bypassed, so dependent instructions can follow back to back.
//
// reset clears the registers, the program counter and the program length;
// the byte memory keeps whatever it held and must be stored before loaded.
// when the receiver stalls, the result register holds and instr.ready drops
// as soon as the execute register is occupied as well.
module toy_register_machine_execute (
  input logic         clk,
  input logic         rst,
  trm_instr_if.sink   instr,
  trm_result_if.source result,
  trm_cfg_if.sink     cfg
);
  import trm_pkg::*;

  logic                e_valid;
  in_item_t            e_item;
  in_item_t            in_item;
  logic                e_fire;
  logic                accept;
  logic                arith;
  logic [RIDX_W-1:0]   rd_addr0;
  logic [RIDX_W-1:0]   rd_addr1;
  logic [REG_W-1:0]    opnd0;
  logic [REG_W-1:0]    opnd1;
  logic [BYTE_W-1:0]   mem_q;
  logic                mem_fwd;
  logic [BYTE_W-1:0]   mem_fwd_data;
  logic [BYTE_W-1:0]   load_byte;
  logic [PC_W-1:0]     pc;
  logic [PC_W-1:0]     prog_len;
  exec_t               ex;

  assign in_item = '{op: instr.op, reg_a: instr.reg_a, reg_b: instr.reg_b,
                     reg_c: instr.reg_c, mem_addr: instr.mem_addr, cond: instr.cond,
                     target_line: instr.target_line, read_value: instr.read_value};

  assign e_fire      = e_valid && (!result.valid || result.ready);
  assign instr.ready = !e_valid || e_fire;
  assign accept      = instr.valid && instr.ready;
  assign cfg.ready   = 1'b1;

  // arithmetic reads b and c, everything else reads a and b
  assign arith    = instr.op inside {OP_ADD, OP_SUB, OP_MUL};
  assign rd_addr0 = arith ? instr.reg_b[RIDX_W-1:0] : instr.reg_a[RIDX_W-1:0];
  assign rd_addr1 = arith ? instr.reg_c[RIDX_W-1:0] : instr.reg_b[RIDX_W-1:0];

  trm_regfile u_regfile (
    .clk(clk), .rst(rst),
    .rd_en(accept), .rd_addr0(rd_addr0), .rd_addr1(rd_addr1),
    .rd_data0(opnd0), .rd_data1(opnd1),
    .wr_en(e_fire && ex.reg_we), .wr_addr(e_item.reg_a[RIDX_W-1:0]),
    .wr_data(ex.reg_wdata)
  );

  trm_ram #(.WIDTH(BYTE_W), .DEPTH(MEM_DEPTH)) u_bytemem (
    .clk(clk), .we(e_fire && ex.mem_we), .waddr(e_item.mem_addr[MADDR_W-1:0]),
    .wdata(ex.mem_wdata), .re(accept), .raddr(instr.mem_addr[MADDR_W-1:0]),
    .rdata(mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_fwd <= 1'b0;
    end else if (accept) begin
      mem_fwd <= e_fire && ex.mem_we &&
                 (e_item.mem_addr[MADDR_W-1:0] == instr.mem_addr[MADDR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_fwd_data <= ex.mem_wdata;
    end
  end

  assign load_byte = mem_fwd ? mem_fwd_data : mem_q;

  trm_alu u_alu (
    .item(e_item), .opnd0(opnd0), .opnd1(opnd1), .load_byte(load_byte),
    .pc(pc), .prog_len(prog_len), .ex(ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (instr.ready) begin
      e_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      prog_len <= '0;
    end else begin
      if (e_fire) begin
        pc <= ex.next_pc;
      end
      if (cfg.valid) begin
        prog_len <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (e_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      result.next_index  <= ex.next_pc;
      result.halted      <= ex.halted;
      result.print_valid <= ex.print_valid;
      result.print_reg   <= ex.print_reg;
      result.print_value <= ex.print_value;
    end
  end

endmodule

@@ rtl/trm_ram.sv @@
module trm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/trm_regfile.sv @@
module trm_regfile (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [trm_pkg::RIDX_W-1:0] rd_addr0,
  input  logic [trm_pkg::RIDX_W-1:0] rd_addr1,
  output logic [trm_pkg::REG_W-1:0]  rd_data0,
  output logic [trm_pkg::REG_W-1:0]  rd_data1,
  input  logic                       wr_en,
  input  logic [trm_pkg::RIDX_W-1:0] wr_addr,
  input  logic [trm_pkg::REG_W-1:0]  wr_data
);
  import trm_pkg::*;

  logic [REG_W-1:0]    ram0_q;
  logic [REG_W-1:0]    ram1_q;
  logic [NUM_REGS-1:0] vld;
  logic                vld0_q;
  logic                vld1_q;
  logic                fwd0;
  logic                fwd1;
  logic [REG_W-1:0]    fwd_data;

  // two copies give two read ports
  trm_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGS)) u_bank0 (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rd_addr0), .rdata(ram0_q)
  );

  trm_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGS)) u_bank1 (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rd_addr1), .rdata(ram1_q)
  );

  // registers never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      fwd0   <= 1'b0;
      fwd1   <= 1'b0;
    end else if (rd_en) begin
      vld0_q <= vld[rd_addr0];
      vld1_q <= vld[rd_addr1];
      // a write in the same cycle bypasses the bank
      fwd0   <= wr_en && (wr_addr == rd_addr0);
      fwd1   <= wr_en && (wr_addr == rd_addr1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  assign rd_data0 = fwd0 ? fwd_data : (vld0_q ? ram0_q : '0);
  assign rd_data1 = fwd1 ? fwd_data : (vld1_q ? ram1_q : '0);

endmodule

@@ rtl/trm_alu.sv @@
module trm_alu (
  input  trm_pkg::in_item_t            item,
  input  logic [trm_pkg::REG_W-1:0]    opnd0,
  input  logic [trm_pkg::REG_W-1:0]    opnd1,
  input  logic [trm_pkg::BYTE_W-1:0]   load_byte,
  input  logic [trm_pkg::PC_W-1:0]     pc,
  input  logic [trm_pkg::PC_W-1:0]     prog_len,
  output trm_pkg::exec_t               ex
);
  import trm_pkg::*;

  logic [PC_W-1:0] len_lim;
  logic [PC_W-1:0] pc_inc;
  logic [PC_W-1:0] jump_idx;
  logic [PC_W-1:0] next_pc;
  logic            cmp;
  logic            stopped;

  assign len_lim  = (prog_len > PROG_LIMIT) ? PROG_LIMIT : prog_len;
  assign stopped  = pc >= len_lim;
  assign pc_inc   = pc + PC_W'(1);
  // line zero is taken as the first line
  assign jump_idx = (item.target_line == '0) ? '0 : item.target_line - PC_W'(1);

  always_comb begin
    case (item.cond)
      CMP_EQ:  cmp = opnd0 == opnd1;
      CMP_GT:  cmp = $signed(opnd0) >  $signed(opnd1);
      CMP_LT:  cmp = $signed(opnd0) <  $signed(opnd1);
      CMP_GE:  cmp = $signed(opnd0) >= $signed(opnd1);
      CMP_LE:  cmp = $signed(opnd0) <= $signed(opnd1);
      default: cmp = 1'b0;
    endcase
  end

  always_comb begin
    ex             = '0;
    next_pc        = pc_inc;
    ex.mem_wdata   = opnd0[BYTE_W-1:0];
    case (item.op)
      OP_STORE: ex.mem_we = 1'b1;
      OP_LOAD: begin
        ex.reg_we    = 1'b1;
        ex.reg_wdata = {{(REG_W-BYTE_W){load_byte[BYTE_W-1]}}, load_byte};
      end
      OP_ADD: begin
        ex.reg_we    = 1'b1;
        ex.reg_wdata = opnd0 + opnd1;
      end
      OP_SUB: begin
        ex.reg_we    = 1'b1;
        ex.reg_wdata = opnd0 - opnd1;
      end
      OP_MUL: begin
        ex.reg_we    = 1'b1;
        ex.reg_wdata = opnd0 * opnd1;
      end
      OP_READ: begin
        ex.reg_we    = 1'b1;
        ex.reg_wdata = item.read_value;
      end
      OP_PRINT: begin
        ex.print_valid = 1'b1;
        ex.print_reg   = item.reg_a;
        ex.print_value = opnd0;
      end
      OP_IF: begin
        // branch taken when the test fails
        if (!cmp) begin
          next_pc = jump_idx;
        end
      end
      OP_JMP:  next_pc = jump_idx;
      default: next_pc = pc_inc;
    endcase

    if (stopped) begin
      ex.next_pc     = pc;
      ex.halted      = 1'b1;
      ex.print_valid = 1'b0;
      ex.print_reg   = '0;
      ex.print_value = '0;
      ex.reg_we      = 1'b0;
      ex.mem_we      = 1'b0;
    end else begin
      ex.next_pc = next_pc;
      ex.halted  = next_pc >= len_lim;
    end
  end

endmodule

@@ rtl/trm_checker.sv @@
module trm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      instr_valid,
  input logic                      instr_ready,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic                      result_print_valid,
  input logic [trm_pkg::RSEL_W-1:0] result_print_reg,
  input logic [trm_pkg::REG_W-1:0]  result_print_value
);
  import trm_pkg::*;

  // a result is offered after its instruction has passed the execute register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (instr_valid && instr_ready) |-> ##2 result_valid)
    else $error("no result two cycles after an accepted instruction");

  // an empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> instr_ready)
    else $error("input stalled while the output stage is empty");

  a_print_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_print_valid) |->
      (result_print_reg == '0 && result_print_value == '0))
    else $error("print fields set on a result that is not a print");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result withdrawn before it was taken");

endmodule

bind toy_register_machine_execute trm_checker u_trm_checker (
  .clk(clk),
  .rst(rst),
  .instr_valid(instr.valid),
  .instr_ready(instr.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_print_valid(result.print_valid),
  .result_print_reg(result.print_reg),
  .result_print_value(result.print_value)
);

@@ verif/toy_register_machine_execute_test.sv @@
`timescale 1ns / 100ps

module toy_register_machine_execute_test;
  import trm_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int PHASES          = 11;
  localparam int PHASE_STEPS     = 170;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 80;
  localparam int MAX_PRINTED     = 40;

  // opcodes and compare codes that the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_SPARE_FIRST = OP_IF + 1'b1;
  localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 4'd15;
  localparam logic [COND_W-1:0] CMP_NONE       = 4'd0;

  typedef struct packed {
    logic [PC_W-1:0]   next_index;
    logic              halted;
    logic              print_valid;
    logic [RSEL_W-1:0] print_reg;
    logic [REG_W-1:0]  print_value;
  } step_out_t;

  typedef struct packed {
    logic            set_length;
    logic [PC_W-1:0] length;
    in_item_t        instr;
    logic            typed;
    step_out_t       want;
  } stim_row_t;

  logic clk;
  logic rst;

  trm_instr_if  instr_bus ();
  trm_result_if result_bus ();
  trm_cfg_if    cfg_bus ();

  toy_register_machine_execute DUT (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // machine state as the testbench tracks it
  logic [REG_W-1:0]   gpr [NUM_REGS];
  logic [BYTE_W-1:0]  byte_mem [MEM_DEPTH];
  bit                 byte_written [MEM_DEPTH];
  logic [MADDR_W-1:0] stored_addrs [$];
  logic [PC_W-1:0]    pc_now;
  logic [PC_W-1:0]    prog_len;

  step_out_t step_outcomes [$];
  int        mismatch_count = 0;
  int        src_idle_pct   = 0;
  int        sink_stall_pct = 0;
  bit        long_hold_req  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic int unsigned active_length();
    return (prog_len > PROG_DEPTH) ? PROG_DEPTH : prog_len;
  endfunction

  function automatic step_out_t execute_step(in_item_t it);
    step_out_t        out;
    int unsigned      lim;
    logic [PC_W-1:0]  nxt;
    logic [PC_W-1:0]  jump_idx;
    logic [REG_W-1:0] x;
    logic [REG_W-1:0] y;
    bit               holds;
    out = '0;
    lim = active_length();
    if (pc_now >= lim) begin
      out.next_index = pc_now;
      out.halted     = 1'b1;
      return out;
    end
    nxt      = pc_now + 1'b1;
    jump_idx = (it.target_line == '0) ? '0 : it.target_line - 1'b1;
    x        = gpr[it.reg_a];
    y        = gpr[it.reg_b];
    case (it.op)
      OP_STORE: begin
        byte_mem[it.mem_addr] = x[BYTE_W-1:0];
        if (!byte_written[it.mem_addr]) begin
          byte_written[it.mem_addr] = 1'b1;
          stored_addrs.push_back(it.mem_addr);
        end
      end
      OP_LOAD: gpr[it.reg_a] = {{(REG_W-BYTE_W){byte_mem[it.mem_addr][BYTE_W-1]}},
                                byte_mem[it.mem_addr]};
      OP_ADD:  gpr[it.reg_a] = y + gpr[it.reg_c];
      OP_SUB:  gpr[it.reg_a] = y - gpr[it.reg_c];
      OP_MUL:  gpr[it.reg_a] = y * gpr[it.reg_c];
      OP_READ: gpr[it.reg_a] = it.read_value;
      OP_PRINT: begin
        out.print_valid = 1'b1;
        out.print_reg   = it.reg_a;
        out.print_value = x;
      end
      OP_IF: begin
        case (it.cond)
          CMP_EQ:  holds = (x == y);
          CMP_GT:  holds = ($signed(x) > $signed(y));
          CMP_LT:  holds = ($signed(x) < $signed(y));
          CMP_GE:  holds = ($signed(x) >= $signed(y));
          CMP_LE:  holds = ($signed(x) <= $signed(y));
          default: holds = 1'b0;
        endcase
        // branch is taken when the comparison fails
        if (!holds) nxt = jump_idx;
      end
      OP_JMP:  nxt = jump_idx;
      default: ;
    endcase
    pc_now         = nxt;
    out.next_index = nxt;
    out.halted     = (nxt >= lim);
    return out;
  endfunction

  function automatic in_item_t mk(int unsigned op, int unsigned a, int unsigned b,
                                  int unsigned c, int unsigned addr, int unsigned cond,
                                  int unsigned tgt, logic [REG_W-1:0] val);
    in_item_t it;
    it.op          = OP_W'(op);
    it.reg_a       = RSEL_W'(a);
    it.reg_b       = RSEL_W'(b);
    it.reg_c       = RSEL_W'(c);
    it.mem_addr    = ADDR_W'(addr);
    it.cond        = COND_W'(cond);
    it.target_line = PC_W'(tgt);
    it.read_value  = val;
    return it;
  endfunction

  function automatic stim_row_t length_row(int unsigned len);
    stim_row_t r;
    r            = '0;
    r.set_length = 1'b1;
    r.length     = PC_W'(len);
    return r;
  endfunction

  function automatic stim_row_t plain(in_item_t it);
    stim_row_t r;
    r       = '0;
    r.instr = it;
    return r;
  endfunction

  function automatic stim_row_t checked(in_item_t it, int unsigned nxt, bit halted,
                                        bit pv, int unsigned preg, logic [REG_W-1:0] pval);
    stim_row_t r;
    r                  = '0;
    r.instr            = it;
    r.typed            = 1'b1;
    r.want.next_index  = PC_W'(nxt);
    r.want.halted      = halted;
    r.want.print_valid = pv;
    r.want.print_reg   = RSEL_W'(preg);
    r.want.print_value = pval;
    return r;
  endfunction

  function automatic in_item_t pick_instr(bit allow_halt);
    in_item_t    it;
    int unsigned roll;
    int unsigned lim;
    lim            = active_length();
    it.reg_a       = RSEL_W'($urandom_range(NUM_REGS-1, 0));
    it.reg_b       = RSEL_W'($urandom_range(NUM_REGS-1, 0));
    it.reg_c       = RSEL_W'($urandom_range(NUM_REGS-1, 0));
    it.mem_addr    = ADDR_W'($urandom_range(MEM_DEPTH-1, 0));
    it.cond        = ($urandom_range(99, 0) < 75) ? COND_W'($urandom_range(CMP_LE, CMP_EQ))
                                                  : COND_W'($urandom_range(15, 0));
    // small values make equal registers and sign flips common
    roll = $urandom_range(99, 0);
    if (roll < 35) begin
      it.read_value = $urandom_range(6, 0) - 3;
    end else if (roll < 50) begin
      case ($urandom_range(3, 0))
        0:       it.read_value = {1'b0, {(REG_W-1){1'b1}}};
        1:       it.read_value = {1'b1, {(REG_W-1){1'b0}}};
        2:       it.read_value = '1;
        default: it.read_value = '0;
      endcase
    end else begin
      it.read_value = $urandom;
    end
    roll = $urandom_range(99, 0);
    if (roll < 5) it.target_line = '0;
    else if (allow_halt && roll < 25) it.target_line = PC_W'($urandom_range(PROG_DEPTH, 1));
    else it.target_line = PC_W'($urandom_range((lim == 0) ? 1 : lim, 1));
    roll = $urandom_range(99, 0);
    if (roll < 14)      it.op = OP_READ;
    else if (roll < 24) it.op = OP_STORE;
    else if (roll < 34) it.op = OP_LOAD;
    else if (roll < 44) it.op = OP_ADD;
    else if (roll < 52) it.op = OP_SUB;
    else if (roll < 60) it.op = OP_MUL;
    else if (roll < 70) it.op = OP_PRINT;
    else if (roll < 82) it.op = OP_IF;
    else if (roll < 88) it.op = OP_JMP;
    else if (roll < 93) it.op = OP_NOP;
    else begin
      roll  = $urandom_range(5, 0);
      it.op = (roll < 5) ? OP_SPARE_FIRST + OP_W'(roll) : OP_SPARE_LAST;
    end
    // loads only from bytes that were stored
    if (it.op == OP_LOAD) begin
      if (stored_addrs.size() == 0) it.op = OP_STORE;
      else it.mem_addr = stored_addrs[$urandom_range(stored_addrs.size()-1, 0)];
    end
    // stay inside the program unless this phase may run off its end
    if (!allow_halt && pc_now < lim && pc_now + 1 >= lim) it.op = OP_JMP;
    return it;
  endfunction

  task automatic offer_instr(in_item_t it);
    if (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
      instr_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < src_idle_pct);
    end
    instr_bus.valid       <= 1'b1;
    instr_bus.op          <= it.op;
    instr_bus.reg_a       <= it.reg_a;
    instr_bus.reg_b       <= it.reg_b;
    instr_bus.reg_c       <= it.reg_c;
    instr_bus.mem_addr    <= it.mem_addr;
    instr_bus.cond        <= it.cond;
    instr_bus.target_line <= it.target_line;
    instr_bus.read_value  <= it.read_value;
    @(posedge clk);
    while (!instr_bus.ready) @(posedge clk);
  endtask

  task automatic run_step(in_item_t it);
    step_outcomes.push_back(execute_step(it));
    offer_instr(it);
  endtask

  task automatic set_program_length(logic [PC_W-1:0] len);
    instr_bus.valid <= 1'b0;
    while (step_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= len;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    prog_len = len;
  endtask

  // result side: checks every transaction and decides ready for the next cycle
  initial begin : result_sink
    int        hold_left;
    step_out_t got;
    step_out_t want;
    hold_left        = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        got.next_index  = result_bus.next_index;
        got.halted      = result_bus.halted;
        got.print_valid = result_bus.print_valid;
        got.print_reg   = result_bus.print_reg;
        got.print_value = result_bus.print_value;
        if (step_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, next_index %0d",
                                    got.next_index));
        end else begin
          want = step_outcomes.pop_front();
          if (got.next_index !== want.next_index)
            report_mismatch($sformatf("next_index %0d, expected %0d",
                                      got.next_index, want.next_index));
          if (got.halted !== want.halted)
            report_mismatch($sformatf("halted %b, expected %b", got.halted, want.halted));
          if (got.print_valid !== want.print_valid)
            report_mismatch($sformatf("print_valid %b, expected %b",
                                      got.print_valid, want.print_valid));
          if (got.print_reg !== want.print_reg)
            report_mismatch($sformatf("print_reg %0d, expected %0d",
                                      got.print_reg, want.print_reg));
          if (got.print_value !== want.print_value)
            report_mismatch($sformatf("print_value %h, expected %h",
                                      got.print_value, want.print_value));
        end
      end
      if (long_hold_req) begin
        hold_left     = HOLD_CYCLES;
        long_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   walk_rows [$];
    stim_row_t   row;
    int unsigned len;
    int          executed;
    int          ignored;
    bit          allow_halt;
    rst                   <= 1'b1;
    instr_bus.valid       <= 1'b0;
    instr_bus.op          <= '0;
    instr_bus.reg_a       <= '0;
    instr_bus.reg_b       <= '0;
    instr_bus.reg_c       <= '0;
    instr_bus.mem_addr    <= '0;
    instr_bus.cond        <= '0;
    instr_bus.target_line <= '0;
    instr_bus.read_value  <= '0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.data          <= '0;
    foreach (gpr[i]) gpr[i] = '0;
    pc_now   = '0;
    prog_len = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // step with no program, then the extremes of every operation
    walk_rows.push_back(checked(mk(OP_NOP, 0, 0, 0, 0, CMP_NONE, 1, '0), 0, 1, 0, 0, '0));
    walk_rows.push_back(length_row(0));
    walk_rows.push_back(checked(mk(OP_NOP, 0, 0, 0, 0, CMP_NONE, 1, '0), 0, 1, 0, 0, '0));
    walk_rows.push_back(length_row(PROG_DEPTH));
    walk_rows.push_back(checked(mk(OP_READ, 0, 0, 0, 0, CMP_NONE, 1, 32'h7fffffff),
                                1, 0, 0, 0, '0));
    walk_rows.push_back(checked(mk(OP_READ, 1, 0, 0, 0, CMP_NONE, 1, 32'h80000000),
                                2, 0, 0, 0, '0));
    walk_rows.push_back(checked(mk(OP_PRINT, 0, 0, 0, 0, CMP_NONE, 1, '0),
                                3, 0, 1, 0, 32'h7fffffff));
    walk_rows.push_back(checked(mk(OP_PRINT, 1, 0, 0, 0, CMP_NONE, 1, '0),
                                4, 0, 1, 1, 32'h80000000));
    walk_rows.push_back(plain(mk(OP_ADD, 2, 0, 1, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_SUB, 3, 1, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_MUL, 4, 0, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_STORE, 0, 0, 0, MEM_DEPTH-1, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_LOAD, 5, 0, 0, MEM_DEPTH-1, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_STORE, 3, 0, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_LOAD, 6, 0, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_PRINT, 5, 0, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_IF, 0, 0, 0, 0, CMP_EQ, 1, '0)));
    walk_rows.push_back(plain(mk(OP_IF, 0, 1, 0, 0, CMP_GT, 1, '0)));
    walk_rows.push_back(plain(mk(OP_IF, 1, 0, 0, 0, CMP_LT, 1, '0)));
    walk_rows.push_back(plain(mk(OP_IF, 0, 0, 0, 0, CMP_GE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_IF, 0, 1, 0, 0, CMP_LE, 40, '0)));
    // unknown compare is false, lands on the last line
    walk_rows.push_back(plain(mk(OP_IF, 0, 0, 0, 0, CMP_NONE, PROG_DEPTH, '0)));
    // line zero acts as line one
    walk_rows.push_back(checked(mk(OP_JMP, 0, 0, 0, 0, CMP_NONE, 0, '0), 0, 0, 0, 0, '0));
    walk_rows.push_back(plain(mk(OP_SPARE_FIRST, 0, 0, 0, 0, CMP_NONE, 1, '0)));
    walk_rows.push_back(plain(mk(OP_SPARE_LAST, 0, 0, 0, 0, CMP_NONE, 1, '0)));
    // jump past the end, then a step while halted, then resume
    walk_rows.push_back(length_row(20));
    walk_rows.push_back(checked(mk(OP_JMP, 0, 0, 0, 0, CMP_NONE, 200, '0), 199, 1, 0, 0, '0));
    walk_rows.push_back(checked(mk(OP_PRINT, 0, 0, 0, 0, CMP_NONE, 1, '0), 199, 1, 0, 0, '0));
    walk_rows.push_back(length_row(PROG_DEPTH));
    walk_rows.push_back(plain(mk(OP_PRINT, 7, 0, 0, 0, CMP_NONE, 1, '0)));

    foreach (walk_rows[i]) begin
      row = walk_rows[i];
      if (row.set_length) begin
        set_program_length(row.length);
      end else if (row.typed) begin
        void'(execute_step(row.instr));
        step_outcomes.push_back(row.want);
        offer_instr(row.instr);
      end else begin
        run_step(row.instr);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 51;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 51;
        end
        default: begin
          src_idle_pct   = 14;
          sink_stall_pct = 14;
        end
      endcase
      if (p == 1) len = 1;
      else if (p == 0 || p == 3 || p == 7 || p == PHASES-1) len = PROG_DEPTH;
      else len = $urandom_range(PROG_DEPTH-1, 2);
      // a halted machine only wakes up when the length grows past its pc
      if (len <= pc_now) len = pc_now + 1;
      allow_halt = (p == PHASES-1) || ((p % 3 == 2) && len < PROG_DEPTH-1);
      set_program_length(PC_W'(len));
      executed = 0;
      ignored  = 0;
      while (executed < PHASE_STEPS && ignored < 4) begin
        if (p == PRESSURE_PHASE && executed == 40) long_hold_req = 1;
        if (pc_now < active_length()) executed++;
        else ignored++;
        run_step(pick_instr(allow_halt));
      end
      // back to the first line so the next length applies from the top
      if (pc_now < active_length()) run_step(mk(OP_JMP, 0, 0, 0, 0, CMP_NONE, 1, '0));
    end

    instr_bus.valid <= 1'b0;
    while (step_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ toy_register_machine_execute.f @@
rtl/trm_pkg.sv
rtl/trm_ifs.sv
rtl/trm_ram.sv
rtl/trm_regfile.sv
rtl/trm_alu.sv
rtl/toy_register_machine_execute.sv
rtl/trm_checker.sv
verif/toy_register_machine_execute_test.sv
